/* hdl/sal_pkg.sv */
// shared types, widths and codes for the shift array list unit
// no dependencies
`default_nettype none

package sal_pkg;

    localparam int DEPTH  = 128;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 7;
    localparam int CNT_W  = 8;
    localparam int POS_W  = 8;
    localparam int OP_W   = 3;
    localparam int STAT_W = 3;

    // search is split in groups of eight cells
    localparam int GRP_W  = 3;
    localparam int GRP    = 8;
    localparam int NGRP   = DEPTH / GRP;

    typedef logic [DATA_W-1:0]      data_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef logic [GRP_W-1:0]       grp_t;
    typedef logic [IDX_W-GRP_W-1:0] ngrp_t;

    localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_DEL_HEAD = 3'd1,
        OP_DEL_TAIL = 3'd2,
        OP_DEL_POS  = 3'd3,
        OP_FIND     = 3'd4,
        OP_UPDATE   = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_BADPOS   = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    // what every cell does with its entry
    typedef enum logic [1:0] {
        CK_HOLD   = 2'd0,
        CK_INSERT = 2'd1,
        CK_DELETE = 2'd2,
        CK_WRITE  = 2'd3
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t kind;
        pos_t       pos;
        cnt_t       count;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* hdl/shift_array_list_unit.sv */
// shift array list unit top level: control sequencer, result register and the row of cells
// depends on sal_pkg, sal_cell, sal_search
//
// channel  dir  bits  contents
// -------  ---  ----  ---------------------------------------------------
// s_*      in   48    operation [2:0], position [10:3], value [42:11]
// m_*      out  24    status [2:0], found_index [9:3], entry_count [17:10]
//
// an accepted transaction is latched in S_IDLE, then in S_EXEC the whole row
// of cells shifts or writes at once; a find goes on to S_FIND for the
// registered first-match search over the cells
// the result sits in an output register, so a new transaction is taken while a
// result still waits; a stalled result holds the sequencer before the cells move
// reset clears the count, the sequencer and the result valid; entries need none
`default_nettype none

module shift_array_list_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // operation, position, value, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // status, found_index, entry_count, zero pad
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND
    } state_t;

    state_t                    state_reg, state_next;
    logic [sal_pkg::OP_W-1:0]  op_reg, op_next;
    sal_pkg::pos_t             pos_reg, pos_next;
    sal_pkg::data_t            val_reg, val_next;
    sal_pkg::cnt_t             count_reg, count_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    sal_pkg::status_t          status_reg, status_next;
    sal_pkg::idx_t             fidx_reg, fidx_next;
    sal_pkg::cnt_t             rcount_reg, rcount_next;

    sal_pkg::status_t          status_calc;
    sal_pkg::cell_cmd_t        cmd;
    logic                      out_free;
    logic                      load_result;
    logic                      find_hit;
    sal_pkg::idx_t             find_index;

    sal_pkg::data_t            ent   [sal_pkg::DEPTH];
    logic [sal_pkg::DEPTH-1:0] match;

    // ------------------------------------------------------------------
    // row of cells, each linked to its lower and upper neighbor
    // ------------------------------------------------------------------
    for (genvar i = 0; i < sal_pkg::DEPTH; i++)
    begin : g_cell
        sal_pkg::data_t left_d;
        sal_pkg::data_t right_d;

        if (i == 0)
        begin : g_lo
            assign left_d = '0;
        end
        else
        begin : g_lo_n
            assign left_d = ent[i-1];
        end

        if (i == sal_pkg::DEPTH - 1)
        begin : g_hi
            assign right_d = '0;
        end
        else
        begin : g_hi_n
            assign right_d = ent[i+1];
        end

        sal_cell u_cell (
            .clk        (clk),
            .idx        (sal_pkg::idx_t'(i)),
            .cmd        (cmd),
            .key        (val_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .entry      (ent[i]),
            .match      (match[i])
        );
    end

    sal_search u_search (
        .clk   (clk),
        .match (match),
        .hit   (find_hit),
        .index (find_index)
    );

    // ------------------------------------------------------------------
    // status of the latched operation against the current count
    // ------------------------------------------------------------------
    always_comb
    begin
        status_calc = sal_pkg::STAT_OK;
        case (op_reg)
            sal_pkg::OP_INSERT:
            begin
                if (count_reg == sal_pkg::DEPTH_CNT)
                    status_calc = sal_pkg::STAT_FULL;
                else if (pos_reg > count_reg)
                    status_calc = sal_pkg::STAT_BADPOS;
            end
            sal_pkg::OP_DEL_HEAD, sal_pkg::OP_DEL_TAIL, sal_pkg::OP_FIND:
            begin
                if (count_reg == '0)
                    status_calc = sal_pkg::STAT_EMPTY;
            end
            sal_pkg::OP_DEL_POS:
            begin
                if (count_reg == '0)
                    status_calc = sal_pkg::STAT_EMPTY;
                else if (pos_reg == '0 || pos_reg > count_reg)
                    status_calc = sal_pkg::STAT_BADPOS;
            end
            sal_pkg::OP_UPDATE:
            begin
                if (count_reg == '0)
                    status_calc = sal_pkg::STAT_EMPTY;
                else if (pos_reg >= count_reg)
                    status_calc = sal_pkg::STAT_BADPOS;
            end
            default:
            begin
                // unused codes leave everything alone and report ok
                status_calc = sal_pkg::STAT_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer and next values
    // ------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        status_next = status_reg;
        fidx_next   = fidx_reg;
        rcount_next = rcount_reg;
        load_result = 1'b0;

        cmd.kind  = sal_pkg::CK_HOLD;
        cmd.pos   = pos_reg;
        cmd.count = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tdata[2:0];
                    pos_next   = s_tdata[10:3];
                    val_next   = s_tdata[42:11];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == sal_pkg::OP_FIND && status_calc == sal_pkg::STAT_OK)
                begin
                    // match flags are being registered in the search groups
                    state_next = S_FIND;
                end
                else if (out_free)
                begin
                    load_result = 1'b1;
                    status_next = status_calc;
                    fidx_next   = '0;
                    state_next  = S_IDLE;
                    if (status_calc == sal_pkg::STAT_OK)
                    begin
                        case (op_reg)
                            sal_pkg::OP_INSERT:
                            begin
                                cmd.kind   = sal_pkg::CK_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                            sal_pkg::OP_DEL_HEAD:
                            begin
                                cmd.kind   = sal_pkg::CK_DELETE;
                                cmd.pos    = '0;
                                count_next = count_reg - 1'b1;
                            end
                            sal_pkg::OP_DEL_TAIL:
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            sal_pkg::OP_DEL_POS:
                            begin
                                // one-based position: cells from pos-1 up take the upper neighbor
                                cmd.kind   = sal_pkg::CK_DELETE;
                                cmd.pos    = pos_reg - 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                            sal_pkg::OP_UPDATE:
                            begin
                                cmd.kind = sal_pkg::CK_WRITE;
                            end
                            default:
                            begin
                                cmd.kind = sal_pkg::CK_HOLD;
                            end
                        endcase
                    end
                    rcount_next = count_next;
                end
            end
            S_FIND:
            begin
                if (out_free)
                begin
                    load_result = 1'b1;
                    status_next = find_hit ? sal_pkg::STAT_OK : sal_pkg::STAT_NOTFOUND;
                    fidx_next   = find_hit ? find_index : '0;
                    rcount_next = count_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_result)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // transaction payload and result fields
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        fidx_reg   <= fidx_next;
        rcount_reg <= rcount_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, rcount_reg, fidx_reg, status_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sal_pkg::DEPTH_CNT)
        else $error("entry count above depth");

    a_count_on_result : assert property (@(posedge clk) disable iff (!rst_n)
        !load_result |=> $stable(count_reg))
        else $error("entry count moved without a result");

    a_find_state : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIND |-> op_reg == sal_pkg::OP_FIND && count_reg != '0)
        else $error("search pass without a find on a non-empty list");

    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        load_result && status_next == sal_pkg::STAT_FULL |-> count_reg == sal_pkg::DEPTH_CNT)
        else $error("full reported below depth");

endmodule

`default_nettype wire

/* hdl/sal_cell.sv */
// one list cell: holds one entry, shifts with its neighbors, compares with the key
// depends on sal_pkg
`default_nettype none

module sal_cell (
    input  wire logic              clk,
    input  wire sal_pkg::idx_t     idx,
    input  wire sal_pkg::cell_cmd_t cmd,
    input  wire sal_pkg::data_t    key,
    input  wire sal_pkg::data_t    left_data,
    input  wire sal_pkg::data_t    right_data,
    output sal_pkg::data_t         entry,
    output logic                   match
);

    sal_pkg::data_t entry_reg;
    sal_pkg::data_t entry_next;
    sal_pkg::pos_t  idx_pos;

    assign idx_pos = sal_pkg::pos_t'(idx);

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.kind)
            sal_pkg::CK_INSERT:
            begin
                if (idx_pos == cmd.pos)
                    entry_next = key;
                else if (idx_pos > cmd.pos)
                    entry_next = left_data;
            end
            sal_pkg::CK_DELETE:
            begin
                if (idx_pos >= cmd.pos)
                    entry_next = right_data;
            end
            sal_pkg::CK_WRITE:
            begin
                if (idx_pos == cmd.pos)
                    entry_next = key;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    // only cells below the count take part in a search
    assign match = (sal_pkg::cnt_t'(idx) < cmd.count) && (entry_reg == key);

endmodule

`default_nettype wire

/* hdl/sal_search.sv */
// first-match search over the cell match flags: registered per-group encoders, then group select
// depends on sal_pkg
`default_nettype none

module sal_search (
    input  wire logic                     clk,
    input  wire logic [sal_pkg::DEPTH-1:0] match,
    output logic                          hit,
    output sal_pkg::idx_t                 index
);

    logic          grp_hit_reg  [sal_pkg::NGRP];
    sal_pkg::grp_t grp_idx_reg  [sal_pkg::NGRP];
    logic          grp_hit_next [sal_pkg::NGRP];
    sal_pkg::grp_t grp_idx_next [sal_pkg::NGRP];
    sal_pkg::ngrp_t grp_sel;

    // lowest set flag inside each group of eight
    always_comb
    begin
        for (int g = 0; g < sal_pkg::NGRP; g++)
        begin
            grp_hit_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int b = sal_pkg::GRP - 1; b >= 0; b--)
            begin
                if (match[g*sal_pkg::GRP + b])
                begin
                    grp_hit_next[g] = 1'b1;
                    grp_idx_next[g] = sal_pkg::grp_t'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < sal_pkg::NGRP; g++)
        begin
            grp_hit_reg[g] <= grp_hit_next[g];
            grp_idx_reg[g] <= grp_idx_next[g];
        end
    end

    // lowest group with a hit
    always_comb
    begin
        hit     = 1'b0;
        grp_sel = '0;
        for (int g = sal_pkg::NGRP - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
            begin
                hit     = 1'b1;
                grp_sel = sal_pkg::ngrp_t'(g);
            end
        end
    end

    assign index = {grp_sel, grp_idx_reg[grp_sel]};

endmodule

`default_nettype wire

/* verif/sal_list_checker.sv */
// checker for the shift array list unit: watches both stream channels,
// predicts each result from a shadow copy of the list and compares it
// depends on sal_pkg
`default_nettype none

module sal_list_checker
    import sal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // operation, position, value, zero pad
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // status, found_index, entry_count, zero pad
    output int               mismatches,
    output int               outstanding
);

    typedef struct {
        status_t status;
        idx_t    index;
        cnt_t    count;
    } list_result_t;

    data_t        shadow_list [DEPTH];
    cnt_t         shadow_count = '0;
    list_result_t pending_results [$];
    list_result_t want;
    int           err_tally = 0;

    // one list operation on the shadow copy, returns the result it gives
    function automatic list_result_t apply_list_op(input logic [2:0] op, input pos_t pos,
                                                   input data_t val);
        list_result_t res;
        int           i;
        res.status = STAT_OK;
        res.index  = '0;
        case (op)
            OP_INSERT:
                if (shadow_count == DEPTH_CNT)
                    res.status = STAT_FULL;
                else if (pos > shadow_count)
                    res.status = STAT_BADPOS;
                else
                begin
                    for (i = int'(shadow_count); i > int'(pos); i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = val;
                    shadow_count++;
                end
            OP_DEL_HEAD:
                if (shadow_count == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    for (i = 0; i + 1 < int'(shadow_count); i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            OP_DEL_TAIL:
                if (shadow_count == 0)
                    res.status = STAT_EMPTY;
                else
                    shadow_count--;
            OP_DEL_POS:
                if (shadow_count == 0)
                    res.status = STAT_EMPTY;
                else if (pos == 0 || pos > shadow_count)
                    res.status = STAT_BADPOS;
                else
                begin
                    for (i = int'(pos); i < int'(shadow_count); i++)
                        shadow_list[i-1] = shadow_list[i];
                    shadow_count--;
                end
            OP_FIND:
                if (shadow_count == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.status = STAT_NOTFOUND;
                    for (i = int'(shadow_count) - 1; i >= 0; i--)
                        if (shadow_list[i] == val)
                        begin
                            res.status = STAT_OK;
                            res.index  = idx_t'(i);
                        end
                end
            OP_UPDATE:
                if (shadow_count == 0)
                    res.status = STAT_EMPTY;
                else if (pos >= shadow_count)
                    res.status = STAT_BADPOS;
                else
                    shadow_list[pos] = val;
            default: ;
        endcase
        res.count = shadow_count;
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_list_op(s_tdata[2:0], s_tdata[10:3],
                                                        s_tdata[42:11]));
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d, found_index %0d, %s%0d",
                           m_tdata[2:0], m_tdata[9:3], "entry_count ", m_tdata[17:10]);
                    err_tally++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[2:0] !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
                        err_tally++;
                    end
                    if (m_tdata[9:3] !== want.index)
                    begin
                        $error("found_index: expected %0d, actual %0d", want.index,
                               m_tdata[9:3]);
                        err_tally++;
                    end
                    if (m_tdata[17:10] !== want.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d", want.count,
                               m_tdata[17:10]);
                        err_tally++;
                    end
                end
            end
            outstanding <= pending_results.size();
            mismatches  <= err_tally;
        end
    end

endmodule

`default_nettype wire

/* verif/tb_shift_array_list_unit.sv */
// testbench top for the shift array list unit: clock, reset, stimulus and verdict
// depends on sal_pkg, shift_array_list_unit and sal_list_checker
`default_nettype none

module tb_shift_array_list_unit;
    import sal_pkg::*;

    // codes the block has no operation for, they must leave the list alone
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // generous: a limit on the whole run, well above what all phases need together
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 238;
    localparam int POOL_SIZE    = 16;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;    // operation, position, value, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // status, found_index, entry_count, zero pad

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // idling knobs, percent of cycles
    int gap_pct   = 0;
    int stall_pct = 0;

    // stimulus-side view of the fill level, used to aim positions and to switch between filling and draining
    int    fill_level = 0;
    bit    draining   = 1'b0;
    data_t value_pool [POOL_SIZE];

    always #1 clk = ~clk;

    shift_array_list_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sal_list_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side backpressure, changes only on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // present one transaction, after a random gap, and hold it until taken
    task automatic send_item(input logic [OP_W-1:0] op, input int pos, input data_t val);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, val, pos_t'(pos), op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // keep the aiming level in step with the list
        case (op)
            OP_INSERT:
                if (fill_level < DEPTH && pos <= fill_level)
                    fill_level++;
            OP_DEL_HEAD, OP_DEL_TAIL:
                if (fill_level > 0)
                    fill_level--;
            OP_DEL_POS:
                if (fill_level > 0 && pos >= 1 && pos <= fill_level)
                    fill_level--;
            default: ;
        endcase
    endtask

    // pick a value, mostly from a small pool so finds hit and repeat
    function automatic data_t pick_value();
        if ($urandom_range(99) < 70)
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        return data_t'($urandom);
    endfunction

    // position in [lo, hi], leaning on both ends
    function automatic int pick_pos(input int lo, input int hi);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    initial
    begin
        int               phase;
        int               n;
        int               roll;
        logic [OP_W-1:0]  op;
        int               pos;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h7FFF_FFFF;
        value_pool[3] = 32'h8000_0000;
        for (n = 4; n < POOL_SIZE; n++)
            value_pool[n] = data_t'($urandom);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed: every removal, find and update on an empty list first
        send_item(OP_FIND,     0, 32'h0000_0000);
        send_item(OP_DEL_HEAD, 0, 32'h0000_0000);
        send_item(OP_DEL_TAIL, 0, 32'h0000_0000);
        send_item(OP_DEL_POS,  1, 32'h0000_0000);
        send_item(OP_UPDATE,   0, 32'h0000_0000);
        // insert past the end, then fill with the value extremes
        send_item(OP_INSERT,   1, 32'h1234_5678);
        send_item(OP_INSERT,   0, 32'h7FFF_FFFF);
        send_item(OP_INSERT,   1, 32'h8000_0000);   // append at position equal to count
        send_item(OP_INSERT,   0, 32'hFFFF_FFFF);
        send_item(OP_INSERT,   1, 32'h0000_0000);
        send_item(OP_FIND,     0, 32'h8000_0000);
        send_item(OP_FIND,     0, 32'h0BAD_F00D);   // value missing
        send_item(OP_UPDATE,   4, 32'hAAAA_AAAA);   // update not below count
        send_item(OP_UPDATE,   3, 32'h5555_5555);
        send_item(OP_DEL_POS,  0, 32'h0000_0000);   // position zero is out of range
        send_item(OP_DEL_POS,  5, 32'h0000_0000);   // beyond the count
        send_item(OP_DEL_POS,  2, 32'h0000_0000);
        send_item(OP_SPARE_LO, 0, 32'hFFFF_FFFF);
        send_item(OP_SPARE_HI, 128, 32'hFFFF_FFFF);
        send_item(OP_DEL_HEAD, 0, 32'h0000_0000);
        send_item(OP_DEL_TAIL, 0, 32'h0000_0000);
        send_item(OP_INSERT,   128, 32'h0000_0001); // top position bit
        send_item(OP_DEL_POS,  128, 32'h0000_0000);
        send_item(OP_UPDATE,   128, 32'h0000_0000);
        send_item(OP_FIND,     0, 32'hFFFF_FFFF);

        // random: fill to full, drain to empty, over and over
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 83; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 83; end
                default: begin gap_pct = 30; stall_pct = 30; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (fill_level == DEPTH)
                    draining = 1'b1;
                else if (fill_level == 0)
                    draining = 1'b0;
                roll = $urandom_range(99);
                if ($urandom_range(99) < 8)
                begin
                    // noise: any defined operation at any position from 0 to 128
                    op  = OP_W'($urandom_range(OP_UPDATE, OP_INSERT));
                    pos = $urandom_range(128);
                end
                else
                begin
                    if (!draining)
                        op = (roll < 70) ? OP_INSERT : (roll < 78) ? OP_FIND :
                             (roll < 86) ? OP_UPDATE : (roll < 90) ? OP_DEL_HEAD :
                             (roll < 95) ? OP_DEL_TAIL : OP_DEL_POS;
                    else
                        op = (roll < 12) ? OP_INSERT : (roll < 22) ? OP_FIND :
                             (roll < 32) ? OP_UPDATE : (roll < 52) ? OP_DEL_HEAD :
                             (roll < 72) ? OP_DEL_TAIL : OP_DEL_POS;
                    case (op)
                        OP_INSERT:
                            pos = pick_pos(0, fill_level);
                        OP_UPDATE:
                            pos = (fill_level > 0) ? pick_pos(0, fill_level - 1) : 0;
                        OP_DEL_POS:
                            pos = (fill_level > 0) ? pick_pos(1, fill_level) : 1;
                        default:
                            pos = $urandom_range(128);
                    endcase
                end
                send_item(op, pos, pick_value());
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        // let a late stray result surface before judging
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hdl/sal_pkg.sv
hdl/sal_cell.sv
hdl/sal_search.sv
hdl/shift_array_list_unit.sv
verif/sal_list_checker.sv
verif/tb_shift_array_list_unit.sv
